/* hw/rtl/miq_pkg.sv */
`default_nettype none
package miq_pkg;

  // Default sizes of the two ring halves.
  localparam int unsigned HALF_DEPTH_DEF = 512;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Command codes of an input request.
  localparam logic [1:0] CMD_PUSH_BACK = 2'd0;
  localparam logic [1:0] CMD_PUSH_MID  = 2'd1;
  localparam logic [1:0] CMD_POP       = 2'd2;
  localparam logic [1:0] CMD_NONE      = 2'd3;

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic [10:0]        occupancy;
  } out_res_t;

  // Decoded command as it waits between the front and back parts.
  typedef struct packed {
    logic        push;
    logic        middle;
    logic        pop;
    logic [31:0] value;
  } miq_op_t;

endpackage
`default_nettype wire

/* hw/rtl/miq_front.sv */
`default_nettype none
module miq_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire miq_pkg::in_req_t in_req,
  output logic                 in_full,
  output logic                 op_valid,
  output miq_pkg::miq_op_t     op,
  input  wire logic            op_take
);
  import miq_pkg::*;

  // Two-entry queue of decoded commands.
  miq_op_t    slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  miq_op_t    dec;

  always_comb begin
    dec = '0;
    dec.value = in_req.value;
    unique case (in_req.cmd)
      CMD_PUSH_BACK: dec.push = 1'b1;
      CMD_PUSH_MID: begin
        dec.push   = 1'b1;
        dec.middle = 1'b1;
      end
      CMD_POP:  dec.pop = 1'b1;
      CMD_NONE: dec.push = 1'b0;
      default:  dec.push = 1'b0;
    endcase
  end

  assign in_full  = (cnt_r == 2'd2);
  assign accept   = in_push && !in_full;
  assign op_valid = (cnt_r != 2'd0);
  assign op       = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = accept ? ~wptr_r : wptr_r;
    rptr_nxt = (op_take && op_valid) ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(accept) - 2'(op_take && op_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r[wptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/miq_back.sv */
`default_nettype none
module miq_back #(
  parameter int unsigned HALF_DEPTH = miq_pkg::HALF_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = miq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            op_valid,
  input  wire miq_pkg::miq_op_t op,
  output logic                 op_take,
  output logic                 out_empty,
  output miq_pkg::out_res_t    out_res,
  input  wire logic            out_pop
);
  import miq_pkg::*;

  localparam int unsigned PTR_W = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HALF_DEPTH + 1);
  localparam int unsigned TOT_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HALF_DEPTH - 1);
  localparam logic [TOT_W-1:0] HALF_T   = TOT_W'(HALF_DEPTH);
  localparam logic [TOT_W-1:0] FULL_T   = TOT_W'(2 * HALF_DEPTH);

  localparam logic SQ_READ  = 1'b0;
  localparam logic SQ_WRITE = 1'b1;

  logic [DATA_WIDTH-1:0] front_mem [HALF_DEPTH];
  logic [DATA_WIDTH-1:0] back_mem  [HALF_DEPTH];

  logic             state_r, state_nxt;
  logic [PTR_W-1:0] fh_r, fh_nxt;
  logic [PTR_W-1:0] bh_r, bh_nxt;
  logic [CNT_W-1:0] fc_r, fc_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic             res_valid_r, res_valid_nxt;

  // Values handed from the read step to the write step.
  logic [DATA_WIDTH-1:0] front_rd_r, back_rd_r, val_r;
  logic [PTR_W-1:0]      tail_r;
  logic                  rebal_r, fwd_r, pop_ok_r;
  logic [1:0]            status_r;
  logic [TOT_W-1:0]      occ_r;
  out_res_t              res_r;

  logic [TOT_W-1:0]      total;
  logic                  ok_push, ok_pop, rebal, fwd, full, res_room;
  logic [PTR_W-1:0]      bh_dec, bh1, fh1, back_wr_addr, tail;
  logic [CNT_W-1:0]      fc1, bc1;
  logic [TOT_W-1:0]      tail_sum, bwr_sum;
  logic [63:0]           val_wide, pop_wide;
  logic [DATA_WIDTH-1:0] val, move_val;
  logic [1:0]            status;

  assign op_take  = (state_r == SQ_READ) && op_valid;
  assign res_room = !res_valid_r || out_pop;

  always_comb begin
    val_wide = 64'(op.value);
    val      = val_wide[DATA_WIDTH-1:0];
    total    = TOT_W'(fc_r) + TOT_W'(bc_r);
    full     = (total >= FULL_T);
    ok_push  = op.push && !full;
    ok_pop   = op.pop && (fc_r != '0);

    bh_dec = (bh_r == '0) ? PTR_LAST : bh_r - PTR_W'(1);
    bwr_sum = TOT_W'(bh_r) + TOT_W'(bc_r);
    if (bwr_sum >= HALF_T) begin
      bwr_sum = bwr_sum - HALF_T;
    end
    back_wr_addr = op.middle ? bh_dec : bwr_sum[PTR_W-1:0];

    // The front tail lands at head plus count whether or not a pop happens.
    tail_sum = TOT_W'(fh_r) + TOT_W'(fc_r);
    if (tail_sum >= HALF_T) begin
      tail_sum = tail_sum - HALF_T;
    end
    tail = tail_sum[PTR_W-1:0];

    bc1 = bc_r + CNT_W'(ok_push);
    fc1 = fc_r - CNT_W'(ok_pop);
    bh1 = (ok_push && op.middle) ? bh_dec : bh_r;
    fh1 = ok_pop ? ((fh_r == PTR_LAST) ? '0 : fh_r + PTR_W'(1)) : fh_r;

    rebal = (ok_push || ok_pop) && (bc1 > fc1);
    // The entry that moves is the new value itself when it became the back head.
    fwd = ok_push && (op.middle || (bc_r == '0));

    priority if (op.push && full) begin
      status = STATUS_FULL;
    end else if (op.pop && !ok_pop) begin
      status = STATUS_EMPTY;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fh_nxt        = fh_r;
    bh_nxt        = bh_r;
    fc_nxt        = fc_r;
    bc_nxt        = bc_r;
    res_valid_nxt = res_valid_r && !out_pop;
    unique case (state_r)
      SQ_READ: begin
        if (op_take) begin
          fh_nxt    = fh1;
          fc_nxt    = fc1 + CNT_W'(rebal);
          bc_nxt    = bc1 - CNT_W'(rebal);
          bh_nxt    = rebal ? ((bh1 == PTR_LAST) ? '0 : bh1 + PTR_W'(1)) : bh1;
          state_nxt = SQ_WRITE;
        end
      end
      SQ_WRITE: begin
        if (res_room) begin
          res_valid_nxt = 1'b1;
          state_nxt     = SQ_READ;
        end
      end
      default: state_nxt = SQ_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_READ;
      fh_r        <= '0;
      bh_r        <= '0;
      fc_r        <= '0;
      bc_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fh_r        <= fh_nxt;
      bh_r        <= bh_nxt;
      fc_r        <= fc_nxt;
      bc_r        <= bc_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Read step: both heads are read and the new value goes into the back half.
  always_ff @(posedge clk) begin
    if (op_take) begin
      front_rd_r <= front_mem[fh_r];
      back_rd_r  <= back_mem[bh_r];
      val_r      <= val;
      tail_r     <= tail;
      rebal_r    <= rebal;
      fwd_r      <= fwd;
      pop_ok_r   <= ok_pop;
      status_r   <= status;
      occ_r      <= TOT_W'(fc1) + TOT_W'(bc1);
      if (ok_push) begin
        back_mem[back_wr_addr] <= val;
      end
    end
  end

  assign move_val = fwd_r ? val_r : back_rd_r;

  // Write step: the rebalancing move lands at the front tail.
  always_ff @(posedge clk) begin
    if ((state_r == SQ_WRITE) && res_room && rebal_r) begin
      front_mem[tail_r] <= move_val;
    end
  end

  always_comb begin
    pop_wide = 64'(front_rd_r);
  end

  always_ff @(posedge clk) begin
    if ((state_r == SQ_WRITE) && res_room) begin
      res_r.out_value <= pop_ok_r ? pop_wide[31:0] : 32'sd0;
      res_r.status    <= status_r;
      res_r.occupancy <= 11'(occ_r);
    end
  end

  assign out_empty = !res_valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* hw/rtl/middle_insert_queue_top.sv */
`default_nettype none
// A request accepted by the request queue passes the back part's read step and then its
// rebalancing write step on the front-half memory before its result is registered; the back
// part takes no new request until it has finished the last one and its result has room.
// Reset: rst_n is synchronous and active low; it empties both halves and the request queue.
// The two half memories are not cleared; an entry is only used after it has been written.
module middle_insert_queue_top #(
  parameter int unsigned HALF_DEPTH = miq_pkg::HALF_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = miq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire miq_pkg::in_req_t in_req,
  output logic                 in_full,
  output logic                 out_empty,
  output miq_pkg::out_res_t    out_res,
  input  wire logic            out_pop
);
  import miq_pkg::*;

  // The queue is kept as two ring buffers. The front half holds the older entries and
  // the back half the newer ones; a push at the middle goes onto the head of the back half.
  // After each change, when the back half holds more entries than the front half, the
  // back head moves to the front tail, so the front half always holds at least half the entries.

  // Decoded requests wait in a two-entry queue between the front and back parts, so
  // new requests are taken while the back part works or while a result waits to be popped.
  logic    op_valid;
  logic    op_take;
  miq_op_t op;

  miq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_req   (in_req),
    .in_full  (in_full),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  // The back part owns both memories and the head and count registers. It reads both
  // heads in its first step; in its second step it writes the rebalanced entry and
  // places the result in a one-entry output register.
  miq_back #(
    .HALF_DEPTH (HALF_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op        (op),
    .op_take   (op_take),
    .out_empty (out_empty),
    .out_res   (out_res),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire

/* dv/middle_insert_queue_top_tb.sv */
`timescale 1ns / 1ps

module middle_insert_queue_top_tb;
  import miq_pkg::*;

  localparam int unsigned QUEUE_CAPACITY = 2 * HALF_DEPTH_DEF;

  // One line of the directed table. When has_known is set, known_res is the
  // result written out by hand. Otherwise the row is checked against the
  // predicted result.
  typedef struct packed {
    in_req_t  req;
    logic     has_known;
    out_res_t known_res;
  } stim_row_t;

  localparam int NUM_DIRECTED = 24;

  // The opening rows walk through the queue by hand. They pop an empty queue,
  // try the unused command, push the signed extremes at the back and two more
  // values in the middle, and pop everything back out in queue order. The later
  // rows mix back and middle pushes with pops and are left to the predictor.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{CMD_POP,       32'h0000_0000}, 1'b1, '{32'h0000_0000, STATUS_EMPTY, 11'd0}},
    '{'{CMD_NONE,      32'hFFFF_FFFF}, 1'b1, '{32'h0000_0000, STATUS_OK,    11'd0}},
    '{'{CMD_PUSH_BACK, 32'h7FFF_FFFF}, 1'b1, '{32'h0000_0000, STATUS_OK,    11'd1}},
    '{'{CMD_PUSH_BACK, 32'h8000_0000}, 1'b1, '{32'h0000_0000, STATUS_OK,    11'd2}},
    '{'{CMD_PUSH_MID,  32'hFFFF_FFFF}, 1'b1, '{32'h0000_0000, STATUS_OK,    11'd3}},
    '{'{CMD_PUSH_MID,  32'h0000_0000}, 1'b1, '{32'h0000_0000, STATUS_OK,    11'd4}},
    '{'{CMD_POP,       32'hFFFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, STATUS_OK,    11'd3}},
    '{'{CMD_POP,       32'h0000_0000}, 1'b1, '{32'hFFFF_FFFF, STATUS_OK,    11'd2}},
    '{'{CMD_NONE,      32'h0000_3039}, 1'b1, '{32'h0000_0000, STATUS_OK,    11'd2}},
    '{'{CMD_POP,       32'h0000_0000}, 1'b1, '{32'h0000_0000, STATUS_OK,    11'd1}},
    '{'{CMD_POP,       32'h0000_0000}, 1'b1, '{32'h8000_0000, STATUS_OK,    11'd0}},
    '{'{CMD_POP,       32'h7FFF_FFFF}, 1'b1, '{32'h0000_0000, STATUS_EMPTY, 11'd0}},
    '{'{CMD_PUSH_BACK, 32'h5555_5555}, 1'b0, '0},
    '{'{CMD_PUSH_MID,  32'hAAAA_AAAA}, 1'b0, '0},
    '{'{CMD_PUSH_BACK, 32'h0000_0001}, 1'b0, '0},
    '{'{CMD_PUSH_MID,  32'h0000_0002}, 1'b0, '0},
    '{'{CMD_PUSH_MID,  32'h0000_0003}, 1'b0, '0},
    '{'{CMD_POP,       32'h0000_0000}, 1'b0, '0},
    '{'{CMD_NONE,      32'h0000_0000}, 1'b0, '0},
    '{'{CMD_POP,       32'h0000_0000}, 1'b0, '0},
    '{'{CMD_POP,       32'h0000_0000}, 1'b0, '0},
    '{'{CMD_POP,       32'h0000_0000}, 1'b0, '0},
    '{'{CMD_POP,       32'h0000_0000}, 1'b0, '0},
    '{'{CMD_POP,       32'h0000_0000}, 1'b0, '0}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  in_req_t  in_req = '0;
  logic     in_full;
  logic     out_empty;
  out_res_t out_res;
  logic     out_pop = 1'b0;

  // The predictor's copy of the queue. Both halves are plain SystemVerilog
  // queues, with index 0 as the head of each half.
  logic [31:0] front_half[$];
  logic [31:0] back_half[$];

  // Results that have been predicted for accepted requests and are still
  // waiting to be popped, oldest first.
  out_res_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  middle_insert_queue_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_req    (in_req),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_res   (out_res),
    .out_pop   (out_pop)
  );

  always #1 clk = ~clk;

  function automatic int unsigned queue_occupancy();
    return front_half.size() + back_half.size();
  endfunction

  // Applies one request to the predictor's queue and returns the result that
  // the block should report for it. After any change, the head of the back
  // half moves over whenever the back half has grown larger than the front
  // half. That keeps the front half at ceil(total/2) entries.
  function automatic out_res_t apply_request(input in_req_t req);
    out_res_t res;
    logic     changed;
    res = '{out_value: '0, status: STATUS_OK, occupancy: '0};
    changed = 1'b0;
    case (req.cmd)
      CMD_PUSH_BACK, CMD_PUSH_MID: begin
        if (queue_occupancy() >= QUEUE_CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          if (req.cmd == CMD_PUSH_BACK) back_half.insert(back_half.size(), req.value);
          else back_half.insert(0, req.value);
          changed = 1'b1;
        end
      end
      CMD_POP: begin
        if (front_half.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.out_value = front_half[0];
          front_half.delete(0);
          changed = 1'b1;
        end
      end
      default: ;
    endcase
    if (changed && back_half.size() > front_half.size()) begin
      front_half.insert(front_half.size(), back_half[0]);
      back_half.delete(0);
    end
    res.occupancy = 11'(queue_occupancy());
    return res;
  endfunction

  // Offers one request and holds it until the block takes it. Once the
  // request is accepted, the predicted result, or the one written out by
  // hand, is queued. Between bursts the sender may go quiet.
  // in_push is only lowered when such a gap follows, so the push line never
  // drops and rises again within a single time step.
  task automatic send_request(input in_req_t req, input logic has_known,
                              input out_res_t known_res);
    out_res_t    predicted;
    int unsigned gap;
    in_push <= 1'b1;
    in_req  <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predicted = apply_request(req);
    pending_results.insert(pending_results.size(), has_known ? known_res : predicted);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sends one random request. push_pct sets how many of the pushes and pops
  // are pushes. A small share of requests carry the unused command code, and
  // values are sometimes forced to the signed extremes.
  task automatic send_random(input int unsigned push_pct);
    in_req_t req;
    if ($urandom_range(0, 99) < 3) begin
      req.cmd = CMD_NONE;
    end else if ($urandom_range(0, 99) < push_pct) begin
      req.cmd = $urandom_range(0, 1) ? CMD_PUSH_MID : CMD_PUSH_BACK;
    end else begin
      req.cmd = CMD_POP;
    end
    case ($urandom_range(0, 15))
      0:       req.value = 32'h8000_0000;
      1:       req.value = 32'h7FFF_FFFF;
      default: req.value = $urandom();
    endcase
    send_request(req, 1'b0, '0);
  endtask

  // The sender runs here. Reset comes first, then the directed table, then a
  // pause until the queue has been fully answered. The random part follows in
  // three phases. The first wanders at low occupancy. The second offers only
  // pushes until the queue reaches its capacity. The third mixes pops with
  // pushes that keep running into the full queue.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].has_known,
                   DIRECTED_ROWS[i].known_res);
    end

    // Hold off until every outstanding request has been answered. The block
    // then starts the random part from an idle state.
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    repeat (40) send_random(55);
    while (queue_occupancy() < QUEUE_CAPACITY) send_random(100);
    repeat (30) send_random(60);

    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // The run goes on past the last answer, so that any result the block should
    // not produce gets a chance to show up and be flagged.
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("middle_insert_queue_top test passed");
    end else begin
      $display("middle_insert_queue_top test failed");
    end
    $finish;
  end

  // The receiver runs here. It switches between three stall patterns in
  // stretches of random length. The first pops on every cycle, the second
  // pops on about half of the cycles, and the third mostly holds off. Every
  // result taken is compared field by field with the oldest prediction.
  initial begin
    int unsigned pop_mode;
    int unsigned mode_left;
    out_res_t    want;
    pop_mode  = 0;
    mode_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request outstanding: out_value %h status %0d occupancy %0d",
                   $time, out_res.out_value, out_res.status, out_res.occupancy);
          mismatch_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_res.out_value !== want.out_value) begin
            $display("%0t: out_value mismatch: expected %h, actual %h",
                     $time, want.out_value, out_res.out_value);
            mismatch_count++;
          end
          if (out_res.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_res.status);
            mismatch_count++;
          end
          if (out_res.occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                     $time, want.occupancy, out_res.occupancy);
            mismatch_count++;
          end
        end
      end
      if (mode_left == 0) begin
        pop_mode  = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (pop_mode)
        0:       out_pop <= 1'b1;
        1:       out_pop <= ($urandom_range(0, 1) == 1);
        default: out_pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // A correct run ends well within this limit, even with both sides stalling
  // as hard as they can.
  initial begin
    #2000000;
    $display("middle_insert_queue_top test failed");
    $finish;
  end

endmodule
